>>> sv/fqc_pkg.sv
`default_nettype none

package fqc_pkg;

  // Framing bytes and accumulator seeds.
  localparam logic [7:0]  SYNC_BYTE  = 8'hFF;
  localparam logic [7:0]  END_BYTE   = 8'h99;
  localparam logic [15:0] ROT_SEED   = 16'h13B7;
  localparam logic [7:0]  SWAP_SEED  = 8'h3D;
  localparam logic [7:0]  PLAIN_SEED = 8'h4D;

  // Depth of the command queue between the front and the back.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // One queued command: the payload byte, its framing flags and the
  // accumulator values after this byte has been folded in.
  typedef struct packed {
    logic [7:0]  data;
    logic        hdr;
    logic        last;
    logic [7:0]  xor_acc;
    logic [15:0] rot;
    logic [7:0]  swap;
    logic [7:0]  plain;
  } fqc_rec_t;

  // Output sequencer phases.
  typedef enum logic [9:0] {
    PH_OPEN = 10'b00_0000_0001,
    PH_HDR1 = 10'b00_0000_0010,
    PH_DATA = 10'b00_0000_0100,
    PH_C0   = 10'b00_0000_1000,
    PH_C1   = 10'b00_0001_0000,
    PH_C2   = 10'b00_0010_0000,
    PH_C3   = 10'b00_0100_0000,
    PH_C4   = 10'b00_1000_0000,
    PH_SYNC = 10'b01_0000_0000,
    PH_END  = 10'b10_0000_0000
  } fqc_phase_t;

  // Add a byte, then rotate the 16-bit sum left by one.
  function automatic logic [15:0] fold_rot(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] s;
    s = acc + {8'h00, b};
    return {s[14:0], s[15]};
  endfunction

  // Add a byte, then swap the nibbles of the 8-bit sum.
  function automatic logic [7:0] fold_swap(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] s;
    s = acc + b;
    return {s[3:0], s[7:4]};
  endfunction

endpackage

`default_nettype wire

>>> sv/fqc_ifs.sv
`default_nettype none

// Payload byte channel into the framer.
interface fqc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_last;

  modport source (output valid, output data_byte, output is_last, input ready);
  modport sink (input valid, input data_byte, input is_last, output ready);
endinterface

// Framed byte stream out of the framer.
interface fqc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       frame_end;

  modport source (output valid, output out_byte, output run_last, output frame_end,
                  input ready);
  modport sink (input valid, input out_byte, input run_last, input frame_end,
                output ready);
endinterface

`default_nettype wire

>>> sv/fqc_front.sv
`default_nettype none

module fqc_front (
  input  wire logic       clk,
  input  wire logic       rst_n,
  fqc_in_if.sink          in_ch,
  output fqc_pkg::fqc_rec_t push_rec,
  output logic            push_valid,
  input  wire logic       push_ready
);
  import fqc_pkg::*;

  logic        in_frame_r;
  logic [7:0]  xor_r;
  logic [15:0] rot_r;
  logic [7:0]  swap_r;
  logic [7:0]  plain_r;

  logic [7:0]  xor_nxt;
  logic [15:0] rot_nxt;
  logic [7:0]  swap_nxt;
  logic [7:0]  plain_nxt;
  logic        accept;

  // A transfer happens whenever a byte is valid and the queue has room.
  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid;
  assign accept      = in_ch.valid && push_ready;

  // Fold the incoming byte into all four accumulators.
  assign xor_nxt   = xor_r ^ in_ch.data_byte;
  assign rot_nxt   = fold_rot(rot_r, in_ch.data_byte);
  assign swap_nxt  = fold_swap(swap_r, in_ch.data_byte);
  assign plain_nxt = plain_r + in_ch.data_byte;

  // The command carries the updated sums so the back can build the check bytes.
  always_comb begin
    push_rec.data    = in_ch.data_byte;
    push_rec.hdr     = !in_frame_r;
    push_rec.last    = in_ch.is_last;
    push_rec.xor_acc = xor_nxt;
    push_rec.rot     = rot_nxt;
    push_rec.swap    = swap_nxt;
    push_rec.plain   = plain_nxt;
  end

  // Accumulators reload their seeds after the last byte of a frame.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      xor_r      <= 8'h00;
      rot_r      <= ROT_SEED;
      swap_r     <= SWAP_SEED;
      plain_r    <= PLAIN_SEED;
    end else if (accept) begin
      in_frame_r <= !in_ch.is_last;
      if (in_ch.is_last) begin
        xor_r   <= 8'h00;
        rot_r   <= ROT_SEED;
        swap_r  <= SWAP_SEED;
        plain_r <= PLAIN_SEED;
      end else begin
        xor_r   <= xor_nxt;
        rot_r   <= rot_nxt;
        swap_r  <= swap_nxt;
        plain_r <= plain_nxt;
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/fqc_queue.sv
`default_nettype none

module fqc_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push_valid,
  input  wire fqc_pkg::fqc_rec_t  push_rec,
  output logic                    push_ready,
  output logic                    head_valid,
  output fqc_pkg::fqc_rec_t       head_rec,
  input  wire logic               pop
);
  import fqc_pkg::*;

  fqc_rec_t           mem_r [QDEPTH];
  logic [QAW-1:0]     wr_ptr_r;
  logic [QAW-1:0]     rd_ptr_r;
  logic [QAW:0]       count_r;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (count_r != QDEPTH[QAW:0]);
  assign head_valid = (count_r != '0);
  assign head_rec   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  // Storage for queued commands.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/fqc_back.sv
`default_nettype none

module fqc_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               head_valid,
  input  wire fqc_pkg::fqc_rec_t  head_rec,
  output logic                    pop,
  fqc_out_if.source               out_ch
);
  import fqc_pkg::*;

  fqc_phase_t  phase_r, phase_nxt;
  logic [15:0] rot_w_r, rot_w_nxt;
  logic [7:0]  swap_w_r, swap_w_nxt;
  logic [7:0]  plain_w_r, plain_w_nxt;

  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        run_last_r;
  logic        frame_end_r;

  logic        adv;
  logic [7:0]  emit_byte;
  logic        emit_run_last;
  logic        emit_frame_end;

  // One byte is produced per cycle whenever a command is queued and the output register can take it.
  assign adv = head_valid && (!out_valid_r || out_ch.ready);

  // Select the next byte of the stream and advance the check byte chain.
  always_comb begin
    phase_nxt      = phase_r;
    rot_w_nxt      = rot_w_r;
    swap_w_nxt     = swap_w_r;
    plain_w_nxt    = plain_w_r;
    emit_byte      = head_rec.data;
    emit_run_last  = 1'b0;
    emit_frame_end = 1'b0;
    pop            = 1'b0;
    case (phase_r)
      PH_OPEN: begin
        if (head_rec.hdr) begin
          emit_byte = SYNC_BYTE;
          phase_nxt = PH_HDR1;
        end else if (head_rec.last) begin
          phase_nxt = PH_C0;
        end else begin
          emit_run_last = 1'b1;
          pop           = adv;
        end
      end
      PH_HDR1: begin
        emit_byte = SYNC_BYTE;
        phase_nxt = PH_DATA;
      end
      PH_DATA: begin
        if (head_rec.last) begin
          phase_nxt = PH_C0;
        end else begin
          emit_run_last = 1'b1;
          pop           = adv;
          phase_nxt     = PH_OPEN;
        end
      end
      PH_C0: begin
        emit_byte   = head_rec.xor_acc;
        rot_w_nxt   = fold_rot(head_rec.rot, head_rec.xor_acc);
        swap_w_nxt  = fold_swap(head_rec.swap, head_rec.xor_acc);
        plain_w_nxt = head_rec.plain + head_rec.xor_acc;
        phase_nxt   = PH_C1;
      end
      PH_C1: begin
        emit_byte   = rot_w_r[15:8];
        swap_w_nxt  = fold_swap(swap_w_r, rot_w_r[15:8]);
        plain_w_nxt = plain_w_r + rot_w_r[15:8];
        phase_nxt   = PH_C2;
      end
      PH_C2: begin
        emit_byte   = rot_w_r[7:0];
        swap_w_nxt  = fold_swap(swap_w_r, rot_w_r[7:0]);
        plain_w_nxt = plain_w_r + rot_w_r[7:0];
        phase_nxt   = PH_C3;
      end
      PH_C3: begin
        emit_byte   = swap_w_r;
        plain_w_nxt = plain_w_r + swap_w_r;
        phase_nxt   = PH_C4;
      end
      PH_C4: begin
        emit_byte = plain_w_r;
        phase_nxt = PH_SYNC;
      end
      PH_SYNC: begin
        emit_byte = SYNC_BYTE;
        phase_nxt = PH_END;
      end
      PH_END: begin
        emit_byte      = END_BYTE;
        emit_run_last  = 1'b1;
        emit_frame_end = 1'b1;
        pop            = adv;
        phase_nxt      = PH_OPEN;
      end
      default: begin
        phase_nxt = PH_OPEN;
      end
    endcase
  end

  // Sequencer state and check byte working registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_OPEN;
    end else if (adv) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rot_w_r   <= rot_w_nxt;
      swap_w_r  <= swap_w_nxt;
      plain_w_r <= plain_w_nxt;
    end
  end

  // Output register decouples the sequencer from the result channel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_byte_r  <= emit_byte;
      run_last_r  <= emit_run_last;
      frame_end_r <= emit_frame_end;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_byte  = out_byte_r;
  assign out_ch.run_last  = run_last_r;
  assign out_ch.frame_end = frame_end_r;

endmodule

`default_nettype wire

>>> sv/framer_with_quad_check_bytes.sv
`default_nettype none

// Channel   Dir  Payload                          Transfer
// in_ch     in   data_byte[7:0], is_last          valid && ready
// out_ch    out  out_byte[7:0], run_last,         valid && ready
//                frame_end
//
// The output sequencer emits one byte per cycle while a command is queued and out_ch
// is not stalled; a frame header adds two bytes and a frame trailer adds seven.
// A four-entry command queue lets input bytes keep arriving while a trailer drains.
// A first output byte passes through the command queue and then the output register
// before it is offered on out_ch.
// Reset is synchronous and active low; it empties the queue and reloads the sums.
// Stalls on out_ch hold the output register and back up into the queue.

module framer_with_quad_check_bytes (
  input  wire logic clk,
  input  wire logic rst_n,
  fqc_in_if.sink    in_ch,
  fqc_out_if.source out_ch
);
  import fqc_pkg::*;

  fqc_rec_t push_rec;
  logic     push_valid;
  logic     push_ready;
  fqc_rec_t head_rec;
  logic     head_valid;
  logic     pop;

  // Front: accepts bytes and keeps the running sums.
  fqc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_rec   (push_rec),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  // Queue of commands between front and back.
  fqc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_rec   (push_rec),
    .push_ready (push_ready),
    .head_valid (head_valid),
    .head_rec   (head_rec),
    .pop        (pop)
  );

  // Back: emits header, payload, check bytes and trailer.
  fqc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_rec   (head_rec),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

>>> dv/framer_with_quad_check_bytes_test.sv
`timescale 1ns / 100ps

module framer_with_quad_check_bytes_test;
  import fqc_pkg::*;

  // Cycles without any transfer before the run is declared hung.
  localparam int HANG_LIMIT = 3000;
  // Length of the deliberate receiver hold-off.
  localparam int HOLD_OFF_CYCLES = 250;
  // Total input items to aim for.
  localparam int TARGET_ITEMS = 320;

  // One expected byte of the framed stream.
  typedef struct packed {
    logic [7:0] value;
    logic       run_last;
    logic       frame_end;
  } framed_byte_t;

  logic clk;
  logic rst_n;

  fqc_in_if  in_ch ();
  fqc_out_if out_ch ();

  framer_with_quad_check_bytes u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Expected framed bytes, oldest first.
  framed_byte_t framed_q[$];
  int mismatches;
  int sent_items;
  int hang_count;
  int stall_left;
  bit idle_en;
  bit long_hold_req;
  framed_byte_t want;

  // Predictor state: frame open flag and the four running check sums.
  logic        pr_open;
  logic [7:0]  pr_xor;
  logic [15:0] pr_rot;
  logic [7:0]  pr_swap;
  logic [7:0]  pr_plain;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Add a byte to the 16-bit sum, then rotate left by one.
  function automatic logic [15:0] add_rotl16(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] s;
    s = acc + 16'(b);
    return {s[14:0], s[15]};
  endfunction

  // Add a byte to the 8-bit sum, then exchange its nibbles.
  function automatic logic [7:0] add_nibswap8(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] s;
    s = acc + b;
    return {s[3:0], s[7:4]};
  endfunction

  function automatic void reload_sums();
    pr_open  = 1'b0;
    pr_xor   = 8'h00;
    pr_rot   = ROT_SEED;
    pr_swap  = SWAP_SEED;
    pr_plain = PLAIN_SEED;
  endfunction

  // Work out the framed bytes caused by one accepted payload byte.
  function automatic void predict_framed_bytes(input logic [7:0] d, input logic last);
    framed_byte_t burst[$];
    logic [7:0]   c0, c1, c2, c3, c4;
    logic [15:0]  r;
    if (!pr_open) begin
      burst.push_back('{SYNC_BYTE, 1'b0, 1'b0});
      burst.push_back('{SYNC_BYTE, 1'b0, 1'b0});
      pr_open = 1'b1;
    end
    burst.push_back('{d, 1'b0, 1'b0});
    pr_xor   = pr_xor ^ d;
    pr_rot   = add_rotl16(pr_rot, d);
    pr_swap  = add_nibswap8(pr_swap, d);
    pr_plain = pr_plain + d;
    if (last) begin
      // c1 and c2 fold in c0, c3 folds in c0 to c2, and c4 folds in c0 to c3.
      c0 = pr_xor;
      r  = add_rotl16(pr_rot, c0);
      c1 = r[15:8];
      c2 = r[7:0];
      c3 = add_nibswap8(add_nibswap8(add_nibswap8(pr_swap, c0), c1), c2);
      c4 = pr_plain + c0 + c1 + c2 + c3;
      burst.push_back('{c0, 1'b0, 1'b0});
      burst.push_back('{c1, 1'b0, 1'b0});
      burst.push_back('{c2, 1'b0, 1'b0});
      burst.push_back('{c3, 1'b0, 1'b0});
      burst.push_back('{c4, 1'b0, 1'b0});
      burst.push_back('{SYNC_BYTE, 1'b0, 1'b0});
      burst.push_back('{END_BYTE, 1'b0, 1'b1});
      reload_sums();
    end
    burst[burst.size()-1].run_last = 1'b1;
    foreach (burst[i]) framed_q.push_back(burst[i]);
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one payload byte and hold it until the transfer happens.
  task automatic send_byte(input logic [7:0] d, input logic last);
    int gap;
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= d;
    in_ch.is_last   <= last;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    predict_framed_bytes(d, last);
    sent_items++;
    if (idle_en) begin
      gap = pick_gap();
      if (gap > 0) begin
        in_ch.valid     <= 1'b0;
        in_ch.data_byte <= 8'($urandom);
        in_ch.is_last   <= 1'($urandom);
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Drop valid and let every expected byte come out.
  task automatic drain_output();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (framed_q.size() != 0);
  endtask

  // Random payload byte, with the framing values showing up often.
  function automatic logic [7:0] pick_payload();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return SYNC_BYTE;
    if (r < 12) return END_BYTE;
    if (r < 15) return 8'h00;
    return 8'($urandom);
  endfunction

  task automatic send_frame(input int len);
    for (int i = 0; i < len; i++) send_byte(pick_payload(), i == len - 1);
  endtask

  // A one-byte frame straight after reset shows the sum seeds.
  task automatic test_seed_frame();
    idle_en = 1'b1;
    send_byte(8'h00, 1'b1);
    drain_output();
  endtask

  // Payload bytes equal to the framing bytes pass through unescaped.
  task automatic test_extreme_bytes();
    idle_en = 1'b1;
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h99, 1'b0);
    send_byte(8'h99, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h99, 1'b1);
    send_byte(8'h01, 1'b1);
    drain_output();
  endtask

  // Back-to-back frames with neither side idling.
  task automatic test_back_to_back();
    idle_en = 1'b0;
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b1);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b1);
    send_byte(8'hFE, 1'b0);
    send_byte(8'h01, 1'b1);
    drain_output();
  endtask

  // The receiver stops for a long stretch while bytes keep coming.
  task automatic test_output_hold_off();
    idle_en = 1'b0;
    long_hold_req = 1'b1;
    send_frame(6);
    send_frame(1);
    send_frame(11);
    send_frame(2);
    drain_output();
  endtask

  // Random frames, mostly short, a few long enough to wrap the sums.
  task automatic test_random_frames();
    int r;
    int len;
    while (sent_items < TARGET_ITEMS) begin
      idle_en = ($urandom_range(0, 99) >= 20);
      r = $urandom_range(0, 99);
      if (r < 85) len = $urandom_range(1, 8);
      else if (r < 97) len = $urandom_range(9, 30);
      else len = $urandom_range(40, 70);
      send_frame(len);
    end
    drain_output();
  endtask

  // Receiver ready: random stalls, plus the requested long hold-off.
  always @(posedge clk) begin
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      stall_left = HOLD_OFF_CYCLES;
    end
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else if (idle_en && $urandom_range(0, 99) < 15) begin
      out_ch.ready <= 1'b0;
      stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(10, 50);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Compare each output transfer with the oldest expected byte.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (framed_q.size() == 0) begin
        $display("%0t: unexpected byte, expected none, actual %h", $time, out_ch.out_byte);
        mismatches++;
      end else begin
        want = framed_q.pop_front();
        if (out_ch.out_byte !== want.value) begin
          $display("%0t: out_byte expected %h actual %h", $time, want.value, out_ch.out_byte);
          mismatches++;
        end
        if (out_ch.run_last !== want.run_last) begin
          $display("%0t: run_last expected %b actual %b", $time, want.run_last,
                   out_ch.run_last);
          mismatches++;
        end
        if (out_ch.frame_end !== want.frame_end) begin
          $display("%0t: frame_end expected %b actual %b", $time, want.frame_end,
                   out_ch.frame_end);
          mismatches++;
        end
      end
    end
  end

  // Hang detection: count cycles without any transfer.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      hang_count = 0;
    end else begin
      hang_count++;
      if (hang_count >= HANG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, HANG_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.is_last   = 1'b0;
    out_ch.ready    = 1'b0;
    mismatches      = 0;
    sent_items      = 0;
    hang_count      = 0;
    stall_left      = 0;
    idle_en         = 1'b1;
    long_hold_req   = 1'b0;
    reload_sums();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_seed_frame();
    test_extreme_bytes();
    test_back_to_back();
    test_output_hold_off();
    test_random_frames();

    // Let any stray bytes show up before the verdict.
    repeat (20) @(posedge clk);
    if (framed_q.size() != 0) begin
      $display("%0t: %0d expected bytes never came out", $time, framed_q.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/fqc_pkg.sv
sv/fqc_ifs.sv
sv/fqc_front.sv
sv/fqc_queue.sv
sv/fqc_back.sv
sv/framer_with_quad_check_bytes.sv
dv/framer_with_quad_check_bytes_test.sv
